/* rtl/wrs_pkg.sv */
// Shared types, constants and tables for the wheel rpm synthesis block.
// No dependencies; every rtl file imports this package.
package wrs_pkg;

    // Pipeline geometry: stage 0 is the input register, the last stage the output register.
    localparam int NUM_STG   = 31;
    localparam int TRIG_LAST = 18;   // sine and cosine registered here
    localparam int SLIP_LAST = 26;   // slip speed registered here
    localparam int DIV_STEPS = 16;
    localparam int CORDIC_N  = 16;

    localparam logic signed [31:0] Q_ONE       = 32'sd65536;
    localparam logic signed [19:0] PI_Q        = 20'sd205887;
    localparam logic signed [19:0] HALF_PI_Q   = 20'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [62:0]        SAT_CAP     = 63'h4000_0000_0000_0000;
    localparam logic [16:0]        UTIL_ONE    = 17'd65536;
    localparam logic [30:0]        GRAVITY_RST = 31'd642908;

    typedef enum logic [2:0] {
        REG_AXLE_WIDTH    = 3'd0,
        REG_FRONT_AXLE    = 3'd1,
        REG_RPM_PER_SPEED = 3'd2,
        REG_DRAG          = 3'd3,
        REG_DOWNFORCE     = 3'd4,
        REG_GRIP          = 3'd5,
        REG_GRAVITY       = 3'd6,
        REG_PEAK_SLIP     = 3'd7
    } t_reg_idx;

    // Registers the slip path reads.
    typedef struct packed {
        logic [30:0] drag;
        logic [30:0] down;
        logic [30:0] grip;
        logic [30:0] gravity;
        logic [30:0] peak;
    } t_slip_cfg;

    // atan(2^-i) in Q16.16
    function automatic logic [15:0] atan_q(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            4'd15:   v = 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/wrs_trig.sv */
// Pipelined 16-step CORDIC giving cosine and sine of the steering angle.
// Depends on wrs_pkg; stage advances come from the top level.
module wrs_trig (
    input  logic                                i_clk,
    input  logic [wrs_pkg::TRIG_LAST:1]         i_adv,
    input  logic signed [17:0]                  i_angle,
    output logic signed [17:0]                  o_cos,
    output logic signed [17:0]                  o_sin
);
    import wrs_pkg::*;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [19:0] z;
        logic               neg;
    } t_cr;

    t_cr r_cr [0:CORDIC_N];
    t_cr n_cr [0:CORDIC_N];
    logic signed [17:0] r_cos, r_sin;

    // stage 1: fold into +-pi/2
    always_comb begin
        logic signed [19:0] a;
        a = 20'(i_angle);
        n_cr[0].x   = CORDIC_GAIN;
        n_cr[0].y   = '0;
        n_cr[0].neg = 1'b0;
        n_cr[0].z   = a;
        if (a > HALF_PI_Q) begin
            n_cr[0].z   = PI_Q - a;
            n_cr[0].neg = 1'b1;
        end else if (a < -HALF_PI_Q) begin
            n_cr[0].z   = -PI_Q - a;
            n_cr[0].neg = 1'b1;
        end
    end

    for (genvar j = 1; j <= CORDIC_N; j++) begin : g_step
        always_comb begin
            t_cr c;
            logic signed [19:0] at;
            c  = r_cr[j-1];
            at = 20'(atan_q(4'(j - 1)));
            if (!c.z[19]) begin
                n_cr[j].x = c.x - (c.y >>> (j - 1));
                n_cr[j].y = c.y + (c.x >>> (j - 1));
                n_cr[j].z = c.z - at;
            end else begin
                n_cr[j].x = c.x + (c.y >>> (j - 1));
                n_cr[j].y = c.y - (c.x >>> (j - 1));
                n_cr[j].z = c.z + at;
            end
            n_cr[j].neg = c.neg;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= CORDIC_N; j++) begin
            if (i_adv[j + 1]) begin
                r_cr[j] <= n_cr[j];
            end
        end
    end

    // last stage: round Q30 to Q16.16
    always_ff @(posedge i_clk) begin
        logic signed [33:0] cx, sy;
        cx = (r_cr[CORDIC_N].x + 34'sd8192) >>> 14;
        sy = (r_cr[CORDIC_N].y + 34'sd8192) >>> 14;
        if (i_adv[TRIG_LAST]) begin
            r_cos <= r_cr[CORDIC_N].neg ? -cx[17:0] : cx[17:0];
            r_sin <= sy[17:0];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

/* rtl/wrs_slip.sv */
// Slip speed pipeline: drag, downforce and grip products, 16-step utilisation
// divider, peak slip scaling. Depends on wrs_pkg; stage advances from the top.
module wrs_slip (
    input  logic                        i_clk,
    input  logic [wrs_pkg::SLIP_LAST:1] i_adv,
    input  wrs_pkg::t_slip_cfg          i_cfg,
    input  logic signed [31:0]          i_vx,
    input  logic signed [31:0]          i_ax,
    output logic signed [48:0]          o_slip
);
    import wrs_pkg::*;

    typedef struct packed {
        logic [62:0] rem;
        logic [62:0] grip;
        logic [16:0] q;
        logic        done;
        logic        neg;
        logic signed [31:0] vmax;
    } t_div;

    // stage 1
    logic [46:0]        r1_vsq;
    logic signed [31:0] r1_ax, r1_vmax;
    // stage 2
    logic [54:0]        r2_dh, r2_wh;
    logic [53:0]        r2_dl, r2_wl;
    logic signed [31:0] r2_ax, r2_vmax;
    // stage 3
    logic [61:0]        r3_drag, r3_down;
    logic signed [31:0] r3_ax, r3_vmax;
    // stage 4
    logic signed [63:0] r4_drive;
    logic [62:0]        r4_gsum;
    logic signed [31:0] r4_vmax;
    // stage 5
    logic [61:0]        r5_gh;
    logic [62:0]        r5_gl, r5_mag;
    logic               r5_neg;
    logic signed [31:0] r5_vmax;
    // stage 6
    logic [62:0]        r6_grip, r6_mag;
    logic               r6_neg;
    logic signed [31:0] r6_vmax;
    // stages 7..23
    t_div r_dv [0:DIV_STEPS];
    t_div n_dv [0:DIV_STEPS];
    // stages 24..26
    logic signed [48:0] r24_ps;
    logic signed [31:0] r24_vmax;
    logic signed [64:0] r25_pv;
    logic signed [48:0] r26_slip;

    logic w_slip_on;
    assign w_slip_on = (i_cfg.peak != '0) && (i_cfg.grip != '0) && (i_cfg.gravity != '0);

    always_ff @(posedge i_clk) begin
        logic signed [63:0] sq;
        sq = i_vx * i_vx;
        if (i_adv[1]) begin
            r1_vsq  <= sq[62:16];
            r1_ax   <= i_ax;
            r1_vmax <= (i_vx > Q_ONE) ? i_vx : Q_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r2_dh   <= i_cfg.drag * r1_vsq[46:23];
            r2_dl   <= i_cfg.drag * r1_vsq[22:0];
            r2_wh   <= i_cfg.down * r1_vsq[46:23];
            r2_wl   <= i_cfg.down * r1_vsq[22:0];
            r2_ax   <= r1_ax;
            r2_vmax <= r1_vmax;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [77:0] d, w;
        d = {r2_dh, 23'd0} + 78'(r2_dl);
        w = {r2_wh, 23'd0} + 78'(r2_wl);
        if (i_adv[3]) begin
            r3_drag <= d[77:16];
            r3_down <= w[77:16];
            r3_ax   <= r2_ax;
            r3_vmax <= r2_vmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[4]) begin
            r4_drive <= 64'(r3_ax) + $signed({2'b00, r3_drag});
            r4_gsum  <= 63'(i_cfg.gravity) + 63'(r3_down);
            r4_vmax  <= r3_vmax;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] m;
        m = r4_drive[63] ? 64'(-r4_drive) : 64'(r4_drive);
        if (i_adv[5]) begin
            r5_gh   <= i_cfg.grip * r4_gsum[62:32];
            r5_gl   <= i_cfg.grip * r4_gsum[31:0];
            r5_mag  <= m[62:0];
            r5_neg  <= r4_drive[63];
            r5_vmax <= r4_vmax;
        end
    end

    // grip saturates at 2^62 raw
    always_ff @(posedge i_clk) begin
        logic [93:0] full;
        full = {r5_gh, 32'd0} + 94'(r5_gl);
        if (i_adv[6]) begin
            r6_grip <= (full[93:16] > 78'(SAT_CAP)) ? SAT_CAP : full[78:16];
            r6_mag  <= r5_mag;
            r6_neg  <= r5_neg;
            r6_vmax <= r5_vmax;
        end
    end

    // divider set-up: zero drive gives 0, drive at or over grip gives one
    always_comb begin
        n_dv[0].rem  = r6_mag;
        n_dv[0].grip = r6_grip;
        n_dv[0].neg  = r6_neg;
        n_dv[0].vmax = r6_vmax;
        n_dv[0].done = (r6_mag == '0) || (r6_mag >= r6_grip);
        n_dv[0].q    = (r6_mag != '0 && r6_mag >= r6_grip) ? UTIL_ONE : '0;
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        always_comb begin
            t_div d;
            logic [62:0] sh;
            logic [16:0] q;
            d  = r_dv[j-1];
            sh = {d.rem[61:0], 1'b0};
            q  = {d.q[15:0], 1'b0};
            if (sh >= d.grip) begin
                sh   = sh - d.grip;
                q[0] = 1'b1;
            end
            n_dv[j] = d;
            if (!d.done) begin
                n_dv[j].rem = sh;
                n_dv[j].q   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= DIV_STEPS; j++) begin
            if (i_adv[j + 7]) begin
                r_dv[j] <= n_dv[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [17:0] util;
        util = r_dv[DIV_STEPS].neg ? -$signed({1'b0, r_dv[DIV_STEPS].q})
                                   :  $signed({1'b0, r_dv[DIV_STEPS].q});
        if (i_adv[24]) begin
            r24_ps   <= $signed({1'b0, i_cfg.peak}) * util;
            r24_vmax <= r_dv[DIV_STEPS].vmax;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [32:0] ps;
        ps = r24_ps[48:16];
        if (i_adv[25]) begin
            r25_pv <= ps * r24_vmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[SLIP_LAST]) begin
            r26_slip <= w_slip_on ? r25_pv[64:16] : '0;
        end
    end

    assign o_slip = r26_slip;

endmodule

/* rtl/wheel_rpm_synthesis.sv */
// Top level of the wheel rpm synthesis block: config registers, pipeline
// control, wheel geometry and rpm scaling. Depends on wrs_pkg, wrs_trig, wrs_slip.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-----------------------------------
//   in       | sink      | i_in_valid / o_in_stall    | speeds, yaw, accel, steer angle
//   out      | source    | o_out_valid / i_out_stall  | steer_out, four wheel rpm
//   cfg      | sink      | i_cfg_we (no handshake)    | i_cfg_index, i_cfg_data
//
// One beat enters per clock while o_in_stall is low; each result passes through 30
// register stages after the input register, which include the 16-step
// utilisation divider that sits between the grip product and the slip scaling.
// Synchronous active-low reset clears the valid bits and the config registers, except gravity (GRAVITY_RST).
// Each stage holds while it is full and the stage after it cannot take, so
// bubbles close up and input is only held off once every stage is occupied.
module wheel_rpm_synthesis (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beat
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_long_speed,
    input  logic signed [31:0] i_lat_speed,
    input  logic signed [31:0] i_yaw_rate,
    input  logic signed [31:0] i_long_accel,
    input  logic signed [17:0] i_steer_angle,
    // result beat
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_steer_out,
    output logic signed [31:0] o_left_front_rpm,
    output logic signed [31:0] o_right_front_rpm,
    output logic signed [31:0] o_left_rear_rpm,
    output logic signed [31:0] o_right_rear_rpm,
    // config
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data
);
    import wrs_pkg::*;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [17:0] steer;
        logic signed [62:0] hp;
        logic signed [62:0] fp;
        logic signed [46:0] half;
        logic signed [47:0] flat;
        logic signed [47:0] lo;
        logic signed [47:0] ro;
        logic signed [17:0] c;
        logic signed [17:0] s;
    } t_geo;

    localparam int OUT_STG = NUM_STG - 1;

    // config registers
    logic [30:0] r_axle, r_front, r_rpm, r_drag, r_down, r_grip, r_grav, r_peak;

    // control
    logic [OUT_STG:0] r_v;
    logic [OUT_STG:0] w_adv;

    // stage 0
    logic signed [31:0] r0_vx, r0_vy, r0_yaw, r0_ax;
    logic signed [17:0] r0_steer;

    // geometry track, stages 1..26
    t_geo r_g [1:SLIP_LAST];
    t_geo n_g [1:SLIP_LAST];

    logic signed [17:0] w_cos, w_sin;
    logic signed [48:0] w_slip;
    t_slip_cfg          w_scfg;

    // stages 27..30
    logic signed [65:0] r27_pl, r27_pr, r27_pf;
    logic signed [51:0] r27_lr, r27_rr;
    logic signed [48:0] r27_slip;
    logic signed [17:0] r27_steer;
    logic signed [51:0] r28_w [0:3];
    logic signed [17:0] r28_steer;
    logic [56:0]        r29_hi [0:3];
    logic [56:0]        r29_lo [0:3];
    logic [3:0]         r29_neg;
    logic signed [17:0] r29_steer;
    logic signed [31:0] r30_rpm [0:3];
    logic signed [17:0] r30_steer;

    // ---- config writes --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axle  <= '0;
            r_front <= '0;
            r_rpm   <= '0;
            r_drag  <= '0;
            r_down  <= '0;
            r_grip  <= '0;
            r_grav  <= GRAVITY_RST;
            r_peak  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_AXLE_WIDTH:    r_axle  <= i_cfg_data;
                REG_FRONT_AXLE:    r_front <= i_cfg_data;
                REG_RPM_PER_SPEED: r_rpm   <= i_cfg_data;
                REG_DRAG:          r_drag  <= i_cfg_data;
                REG_DOWNFORCE:     r_down  <= i_cfg_data;
                REG_GRIP:          r_grip  <= i_cfg_data;
                REG_GRAVITY:       r_grav  <= i_cfg_data;
                REG_PEAK_SLIP:     r_peak  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- pipeline control -----------------------------------------------
    // A stage loads when the output is free or some stage from it onward is empty.
    for (genvar k = 0; k <= OUT_STG; k++) begin : g_adv
        assign w_adv[k] = !i_out_stall || !(&r_v[OUT_STG:k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k <= OUT_STG; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !w_adv[0];
    assign o_out_valid = r_v[OUT_STG];

    // ---- stage 0: input register ----------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_vx    <= i_long_speed;
            r0_vy    <= i_lat_speed;
            r0_yaw   <= i_yaw_rate;
            r0_ax    <= i_long_accel;
            r0_steer <= i_steer_angle;
        end
    end

    // ---- trig and slip tracks -------------------------------------------
    wrs_trig u_trig (
        .i_clk   (i_clk),
        .i_adv   (w_adv[TRIG_LAST:1]),
        .i_angle (r0_steer),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_scfg.drag    = r_drag;
    assign w_scfg.down    = r_down;
    assign w_scfg.grip    = r_grip;
    assign w_scfg.gravity = r_grav;
    assign w_scfg.peak    = r_peak;

    wrs_slip u_slip (
        .i_clk  (i_clk),
        .i_adv  (w_adv[SLIP_LAST:1]),
        .i_cfg  (w_scfg),
        .i_vx   (r0_vx),
        .i_ax   (r0_ax),
        .o_slip (w_slip)
    );

    // ---- geometry track -------------------------------------------------
    // 1: yaw products, 2: half track and lateral term at the front axle,
    // 3: inner/outer longitudinal speeds, 19: picks up cos/sin.
    always_comb begin
        n_g[1]       = '0;
        n_g[1].vx    = r0_vx;
        n_g[1].vy    = r0_vy;
        n_g[1].steer = r0_steer;
        n_g[1].hp    = $signed({1'b0, r_axle}) * r0_yaw;
        n_g[1].fp    = $signed({1'b0, r_front}) * r0_yaw;
        for (int k = 2; k <= SLIP_LAST; k++) begin
            n_g[k] = r_g[k-1];
            if (k == 2) begin
                n_g[k].half = 47'($signed(r_g[k-1].hp[62:17]));
                n_g[k].flat = 48'(r_g[k-1].vy) + 48'($signed(r_g[k-1].fp[62:16]));
            end
            if (k == 3) begin
                n_g[k].lo = 48'(r_g[k-1].vx) - 48'(r_g[k-1].half);
                n_g[k].ro = 48'(r_g[k-1].vx) + 48'(r_g[k-1].half);
            end
            if (k == TRIG_LAST + 1) begin
                n_g[k].c = w_cos;
                n_g[k].s = w_sin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= SLIP_LAST; k++) begin
            if (w_adv[k]) begin
                r_g[k] <= n_g[k];
            end
        end
    end

    // ---- stage 27: projection products, rear speeds ---------------------
    always_ff @(posedge i_clk) begin
        if (w_adv[SLIP_LAST + 1]) begin
            r27_pl    <= r_g[SLIP_LAST].lo * r_g[SLIP_LAST].c;
            r27_pr    <= r_g[SLIP_LAST].ro * r_g[SLIP_LAST].c;
            r27_pf    <= r_g[SLIP_LAST].flat * r_g[SLIP_LAST].s;
            r27_lr    <= 52'(r_g[SLIP_LAST].lo) + 52'(w_slip);
            r27_rr    <= 52'(r_g[SLIP_LAST].ro) + 52'(w_slip);
            r27_slip  <= w_slip;
            r27_steer <= r_g[SLIP_LAST].steer;
        end
    end

    // ---- stage 28: front speeds -----------------------------------------
    always_ff @(posedge i_clk) begin
        logic signed [66:0] sl, sr;
        logic signed [50:0] hl, hr;
        sl = 67'(r27_pl) + 67'(r27_pf);
        sr = 67'(r27_pr) + 67'(r27_pf);
        hl = sl[66:16];
        hr = sr[66:16];
        if (w_adv[SLIP_LAST + 2]) begin
            r28_w[0]  <= 52'(hl) + 52'(r27_slip);
            r28_w[1]  <= 52'(hr) + 52'(r27_slip);
            r28_w[2]  <= r27_lr;
            r28_w[3]  <= r27_rr;
            r28_steer <= r27_steer;
        end
    end

    // ---- stage 29: magnitude times rpm_per_speed, two partials ----------
    always_ff @(posedge i_clk) begin
        logic [51:0] m;
        if (w_adv[SLIP_LAST + 3]) begin
            for (int k = 0; k < 4; k++) begin
                m = r28_w[k][51] ? 52'(-r28_w[k]) : 52'(r28_w[k]);
                r29_hi[k]  <= r_rpm * m[51:26];
                r29_lo[k]  <= r_rpm * m[25:0];
                r29_neg[k] <= r28_w[k][51];
            end
            r29_steer <= r28_steer;
        end
    end

    // ---- stage 30: combine, saturate, restore sign ----------------------
    always_ff @(posedge i_clk) begin
        logic [82:0] full;
        logic [66:0] mag;
        if (w_adv[OUT_STG]) begin
            for (int k = 0; k < 4; k++) begin
                full = {r29_hi[k], 26'd0} + 83'(r29_lo[k]);
                mag  = full[82:16];
                if (r29_neg[k]) begin
                    r30_rpm[k] <= (mag >= 67'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
                end else begin
                    r30_rpm[k] <= (mag > 67'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
                end
            end
            r30_steer <= r29_steer;
        end
    end

    assign o_steer_out       = r30_steer;
    assign o_left_front_rpm  = r30_rpm[0];
    assign o_right_front_rpm = r30_rpm[1];
    assign o_left_rear_rpm   = r30_rpm[2];
    assign o_right_rear_rpm  = r30_rpm[3];

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for wheel_rpm_synthesis: random and directed vehicle
// samples, a scoreboard class that predicts the rpm beats. Needs rtl/wrs_pkg.sv.
module testbench;
    import wrs_pkg::*;

    typedef bit [63:0] u64;

    typedef struct {
        logic signed [31:0] long_speed;
        logic signed [31:0] lat_speed;
        logic signed [31:0] yaw_rate;
        logic signed [31:0] long_accel;
        logic signed [17:0] steer_angle;
    } t_sample;

    typedef struct {
        logic signed [17:0] steer;
        logic signed [31:0] lf;
        logic signed [31:0] rf;
        logic signed [31:0] lr;
        logic signed [31:0] rr;
    } t_wheels;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;    // extra wait after the last booked result is seen
    localparam int HOLD_CYCLES = 300;   // long receiver hold, fills every stage

    // Holds a copy of the registers, predicts each sample's wheel speeds and
    // keeps them in order until the matching beat leaves the block.
    class wheel_speed_book;
        longint  regs[8];
        t_wheels pending_wheels[$];
        int      n_bad;
        int      n_seen;
        int      atan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                    256, 128, 64, 32, 16, 8, 4, 2};

        function new();
            foreach (regs[k]) regs[k] = 0;
            regs[REG_GRAVITY] = GRAVITY_RST;
            n_bad  = 0;
            n_seen = 0;
        endfunction

        // (a*b)>>16 on magnitudes, saturating
        function u64 sat_mulq(u64 a, u64 b);
            u64 hi;
            u64 t;
            hi = b >> 16;
            if (hi != 0 && a > u64'(SAT_CAP) / hi)
                return u64'(SAT_CAP);
            t = a * hi + ((a * (b & 64'hFFFF)) >> 16);
            return (t > u64'(SAT_CAP)) ? u64'(SAT_CAP) : t;
        endfunction

        function void sin_cos(longint ang, output longint c, output longint s);
            bit     flip;
            longint x, y, z, nx;
            flip = 0;
            if (ang > HALF_PI_Q) begin
                ang  = PI_Q - ang;
                flip = 1;
            end else if (ang < -HALF_PI_Q) begin
                ang  = -PI_Q - ang;
                flip = 1;
            end
            x = CORDIC_GAIN;
            y = 0;
            z = ang;
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_steps[i];
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_steps[i];
                end
                x = nx;
            end
            c = (x + 8192) >>> 14;
            s = (y + 8192) >>> 14;
            if (flip)
                c = -c;
        endfunction

        function logic [31:0] speed_to_rpm(longint v);
            u64 mag;
            u64 r;
            mag = (v < 0) ? u64'(-v) : u64'(v);
            r   = sat_mulq(u64'(regs[REG_RPM_PER_SPEED]), mag);
            if (v < 0)
                return (r >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(r));
            return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(r);
        endfunction

        function longint slip_offset(longint vx, longint ax);
            u64     vsq, drag, down, grip, mag, q, rem;
            longint drive, util, vmax, ps;
            if (regs[REG_PEAK_SLIP] == 0 || regs[REG_GRIP] == 0 || regs[REG_GRAVITY] == 0)
                return 0;
            vsq   = u64'(vx * vx) >> 16;
            drag  = sat_mulq(u64'(regs[REG_DRAG]), vsq);
            drive = ax + longint'(drag);
            down  = sat_mulq(u64'(regs[REG_DOWNFORCE]), vsq);
            grip  = sat_mulq(u64'(regs[REG_GRIP]), u64'(regs[REG_GRAVITY]) + down);
            mag   = (drive < 0) ? u64'(-drive) : u64'(drive);
            if (mag == 0) begin
                q = 0;
            end else if (mag >= grip) begin
                q = 65536;
            end else begin
                q   = 0;
                rem = mag;
                for (int i = 0; i < 16; i++) begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= grip) begin
                        rem = rem - grip;
                        q   = q | 1;
                    end
                end
            end
            util = (drive < 0) ? -longint'(q) : longint'(q);
            vmax = (vx > 65536) ? vx : 65536;
            ps   = (regs[REG_PEAK_SLIP] * util) >>> 16;
            return (ps * vmax) >>> 16;
        endfunction

        function t_wheels predict_wheels(t_sample smp);
            t_wheels w;
            longint  vx, vy, r, ax, d, c, s, half, flat, slip;
            vx = smp.long_speed;
            vy = smp.lat_speed;
            r  = smp.yaw_rate;
            ax = smp.long_accel;
            d  = smp.steer_angle;
            sin_cos(d, c, s);
            half = (regs[REG_AXLE_WIDTH] * r) >>> 17;
            flat = vy + ((regs[REG_FRONT_AXLE] * r) >>> 16);
            slip = slip_offset(vx, ax);
            w.steer = smp.steer_angle;
            w.lf = speed_to_rpm((((vx - half) * c + flat * s) >>> 16) + slip);
            w.rf = speed_to_rpm((((vx + half) * c + flat * s) >>> 16) + slip);
            w.lr = speed_to_rpm(vx - half + slip);
            w.rr = speed_to_rpm(vx + half + slip);
            return w;
        endfunction

        function void note_sample(t_sample smp);
            pending_wheels.push_back(predict_wheels(smp));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            n_bad++;
        endtask

        task check_wheels(t_wheels got);
            t_wheels want;
            n_seen++;
            if (pending_wheels.size() == 0) begin
                report("unexpected beat, lf", got.lf, 0);
                return;
            end
            want = pending_wheels.pop_front();
            if (got.steer !== want.steer) report("steer_out", got.steer, want.steer);
            if (got.lf !== want.lf) report("left_front_rpm", got.lf, want.lf);
            if (got.rf !== want.rf) report("right_front_rpm", got.rf, want.rf);
            if (got.lr !== want.lr) report("left_rear_rpm", got.lr, want.lr);
            if (got.rr !== want.rr) report("right_rear_rpm", got.rr, want.rr);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_long_speed = '0;
    logic signed [31:0] i_lat_speed = '0;
    logic signed [31:0] i_yaw_rate = '0;
    logic signed [31:0] i_long_accel = '0;
    logic signed [17:0] i_steer_angle = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [17:0] o_steer_out;
    logic signed [31:0] o_left_front_rpm;
    logic signed [31:0] o_right_front_rpm;
    logic signed [31:0] o_left_rear_rpm;
    logic signed [31:0] o_right_rear_rpm;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [30:0]        i_cfg_data = '0;

    wheel_rpm_synthesis dut (.*);

    wheel_speed_book book = new();
    int  cycles = 0;
    int  n_samples = 0;
    int  n_settings = 0;
    bit  calm = 0;        // no idling on either side while set
    bit  hold_req = 0;    // asks the receiver for one long hold

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: far above the slowest legal run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Result side: values seen here are the ones from before this edge.
    always @(posedge i_clk) begin
        t_wheels w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            w.steer = o_steer_out;
            w.lf    = o_left_front_rpm;
            w.rf    = o_right_front_rpm;
            w.lr    = o_left_rear_rpm;
            w.rr    = o_right_rear_rpm;
            book.check_wheels(w);
        end
    end

    // Receiver stall: mostly free, short bursts, now and then a long one.
    initial begin
        int left;
        int r;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
                i_out_stall <= 1'b0;
            end else if (left > 0) begin
                left--;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= 1'b1;
                    left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [31:0] q16(real v);
        return $rtoi(v * 65536.0);
    endfunction

    // One beat in; the prediction is booked at the accepting edge.
    task send_sample(t_sample smp);
        int gap;
        i_in_valid    <= 1'b1;
        i_long_speed  <= smp.long_speed;
        i_lat_speed   <= smp.lat_speed;
        i_yaw_rate    <= smp.yaw_rate;
        i_long_accel  <= smp.long_accel;
        i_steer_angle <= smp.steer_angle;
        do @(posedge i_clk); while (o_in_stall);
        book.note_sample(smp);
        n_samples++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly plausible driving states, some noise over the full field width.
    function automatic t_sample random_sample();
        t_sample smp;
        int      kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            smp.long_speed  = $urandom;
            smp.lat_speed   = $urandom;
            smp.yaw_rate    = $urandom;
            smp.long_accel  = $urandom;
            smp.steer_angle = $urandom;
        end else begin
            smp.long_speed  = int'($urandom_range(0, 4259840)) - 327680;
            smp.lat_speed   = int'($urandom_range(0, 393216)) - 196608;
            smp.yaw_rate    = int'($urandom_range(0, 262144)) - 131072;
            smp.long_accel  = int'($urandom_range(0, 2293760)) - 1146880;
            smp.steer_angle = (kind == 1) ? 18'($urandom)
                                          : 18'(int'($urandom_range(0, 78644)) - 39322);
        end
        return smp;
    endfunction

    // Sender pause: wait until every booked result has been seen.
    task in_drain();
        i_in_valid <= 1'b0;
        while (book.pending_wheels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Registers change only with the pipeline empty and settled.
    task apply_setting(int phase);
        logic [30:0] v[8];
        logic [30:0] plain[8];
        plain = '{31'd78643, 31'd52429, 31'd2503462, 31'd197, 31'd262, 31'd98304,
                  31'd642908, 31'd7864};
        v = plain;
        case (phase)
            2: foreach (v[k]) v[k] = 31'h7FFF_FFFF;
            3: foreach (v[k]) v[k] = 31'($urandom >> $urandom_range(1, 22));
            4: v[REG_GRIP] = '0;
            5: begin
                v[REG_GRIP]      = 31'd1;    // grip rounds to nothing
                v[REG_GRAVITY]   = 31'd1;
                v[REG_PEAK_SLIP] = 31'd65536;
            end
            6: v[REG_GRAVITY] = '0;
            7: foreach (v[k]) v[k] = '0;
            default: ;
        endcase
        in_drain();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_reg_idx'(k);
            i_cfg_data  <= v[k];
            @(posedge i_clk);
            book.regs[k] = v[k];
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        t_sample smp;
        int      counts[8] = '{60, 300, 120, 150, 100, 120, 80, 50};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 8; phase++) begin
            if (phase > 0)
                apply_setting(phase);
            calm = (phase == 2);
            if (phase == 1) begin
                // field extremes, steering folds and slip corners
                for (int k = 0; k < 20; k++) begin
                    smp = '{default: '0};
                    case (k)
                        1: smp.long_speed = 32'sh7FFF_FFFF;
                        2: smp.long_speed = 32'sh8000_0000;
                        3: begin
                            smp.lat_speed = 32'sh7FFF_FFFF;
                            smp.yaw_rate  = 32'sh7FFF_FFFF;
                        end
                        4: begin
                            smp.lat_speed = 32'sh8000_0000;
                            smp.yaw_rate  = 32'sh8000_0000;
                        end
                        5: smp.long_accel = 32'sh7FFF_FFFF;
                        6: smp.long_accel = 32'sh8000_0000;
                        7: smp.steer_angle = 18'sd102944;
                        8: smp.steer_angle = -18'sd102944;
                        9: smp.steer_angle = 18'sd102945;
                        10: smp.steer_angle = -18'sd102945;
                        11: smp.steer_angle = 18'sh1FFFF;
                        12: smp.steer_angle = 18'sh20000;
                        13: begin
                            smp.long_speed = q16(0.5);
                            smp.long_accel = q16(3.0);
                        end
                        14: smp.long_speed = q16(20.0);
                        15: begin
                            smp.long_speed = q16(-20.0);
                            smp.long_accel = q16(-8.0);
                        end
                        16: begin
                            smp.long_speed = q16(30.0);
                            smp.long_accel = q16(50.0);
                        end
                        17: begin
                            smp.long_speed  = q16(10.0);
                            smp.lat_speed   = q16(1.0);
                            smp.yaw_rate    = q16(1.0);
                            smp.steer_angle = 18'(q16(0.3));
                        end
                        18: begin
                            smp.long_speed = q16(1.0);
                            smp.long_accel = q16(-30.0);
                        end
                        19: begin
                            smp.long_speed  = q16(40.0);
                            smp.yaw_rate    = q16(-1.5);
                            smp.steer_angle = 18'(q16(-0.5));
                        end
                        default: ;
                    endcase
                    send_sample(smp);
                end
            end
            for (int k = 0; k < counts[phase]; k++) begin
                if (phase == 1 && k == 100)
                    hold_req = 1;    // sender keeps offering while the output is held
                send_sample(random_sample());
            end
        end

        in_drain();
        $display("%0d samples over %0d register settings, %0d rpm beats checked",
                 n_samples, n_settings + 1, book.n_seen);
        $display("covered steering folds, slip clamp and cut-off, rpm saturation, long stalls");
        if (book.n_bad == 0 && book.pending_wheels.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d beats missing", book.n_bad,
                     book.pending_wheels.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
